@@ src/fsws_pkg.sv @@
// ----------------------------------------------------------------------------
// fsws_pkg
// Shared widths, constants and types of the flash sector writeback scheduler.
// ----------------------------------------------------------------------------
package fsws_pkg;

   localparam int OFFSET_W     = 18;
   localparam int SIZE_W       = 19;
   localparam int TIME_W       = 64;
   localparam int ADDR_W       = 24;
   localparam int DELAY_W      = 32;
   localparam int CSR_DATA_W   = 32;

   localparam int SECTOR_BYTES = 4096;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int NUM_SECTORS  = 64;
   localparam int SECT_W       = $clog2(NUM_SECTORS);
   localparam int COUNT_W      = $clog2(NUM_SECTORS + 1);

   // byte range end can reach offset + size - 1, one bit past the size width
   localparam int END_W        = SIZE_W + 1;
   localparam int END_SECT_W   = END_W - SECTOR_SHIFT;

   localparam int CMDQ_DEPTH   = 2;
   localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

   localparam logic [DELAY_W-1:0] COMMIT_DELAY_RESET = DELAY_W'(500000);

   // request kinds
   localparam logic REQ_WRITE_NOTICE = 1'b0;
   localparam logic REQ_PROCESS_TICK = 1'b1;

   // flash commands
   localparam logic CMD_ERASE   = 1'b0;
   localparam logic CMD_PROGRAM = 1'b1;

   // configuration register indexes
   localparam logic CSR_FLASH_BASE   = 1'b0;
   localparam logic CSR_COMMIT_DELAY = 1'b1;

   // classified job handed from front to back
   typedef struct packed {
      logic                    is_tick;
      logic [SECT_W-1:0]       first_sector;
      logic [SECT_W-1:0]       last_sector;
      logic [TIME_W-1:0]       now_time;
   } job_type;

endpackage

@@ src/fsws_front.sv @@
// ----------------------------------------------------------------------------
// fsws_front
// Accepts requests, turns a write range into a clamped sector span and drops
// notices that touch no sector. Holds one classified job for the queue.
// ----------------------------------------------------------------------------
module fsws_front
   import fsws_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [OFFSET_W-1:0] req_write_offset,
   input  logic [SIZE_W-1:0]   req_write_size,
   input  logic [TIME_W-1:0]   req_now_time,
   output logic                job_valid,
   input  logic                job_ready,
   output job_type             job
);

   logic                  job_valid_ff, job_valid_in;
   job_type               job_ff, job_in;
   logic                  accept;
   logic                  keep;
   logic [END_W-1:0]      end_byte;
   logic [END_SECT_W-1:0] first_wide;
   logic [END_SECT_W-1:0] last_wide;
   logic [END_SECT_W-1:0] last_clamp;

   assign req_stall = job_valid_ff && !job_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      end_byte   = END_W'(req_write_offset) + END_W'(req_write_size) - END_W'(1);
      first_wide = END_SECT_W'(req_write_offset >> SECTOR_SHIFT);
      last_wide  = END_SECT_W'(end_byte >> SECTOR_SHIFT);
      last_clamp = (last_wide >= END_SECT_W'(NUM_SECTORS)) ?
                   END_SECT_W'(NUM_SECTORS - 1) : last_wide;

      // drop empty notices and ranges starting past the last sector
      keep = (req_type == REQ_PROCESS_TICK) ||
             ((req_write_size != '0) && (first_wide < END_SECT_W'(NUM_SECTORS)));

      job_in.is_tick      = (req_type == REQ_PROCESS_TICK);
      job_in.first_sector = SECT_W'(first_wide);
      job_in.last_sector  = SECT_W'(last_clamp);
      job_in.now_time     = req_now_time;

      job_valid_in = job_valid_ff && !job_ready;
      if (accept) begin
         job_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

@@ src/fsws_job_queue.sv @@
// ----------------------------------------------------------------------------
// fsws_job_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module fsws_job_queue
   import fsws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   job_type                 entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ src/fsws_back.sv @@
// ----------------------------------------------------------------------------
// fsws_back
// Carries out jobs: walks a write span into the pending-sector ring and runs
// the erase, wait, program sequence for the head sector on process ticks.
// ----------------------------------------------------------------------------
module fsws_back
   import fsws_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  job_type            job,
   input  logic [ADDR_W-1:0]  flash_base,
   input  logic [DELAY_W-1:0] commit_delay,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_flash_cmd,
   output logic [SECT_W-1:0]  rsp_sector_index,
   output logic [ADDR_W-1:0]  rsp_flash_address,
   output logic [COUNT_W-1:0] rsp_pending_count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_REFILL
   } state_type;

   typedef enum logic [1:0] {
      PH_WAITING,
      PH_ERASING,
      PH_DELAYING
   } phase_type;

   // pending-sector ring
   logic [SECT_W-1:0]      fifo_mem [NUM_SECTORS];
   logic                   mem_we;
   logic [SECT_W-1:0]      rd_data_ff;
   logic [SECT_W-1:0]      head_next;

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   phase_type              phase_eff;
   logic [TIME_W-1:0]      deadline_ff, deadline_in;
   logic [SECT_W-1:0]      head_ptr_ff, head_ptr_in;
   logic [SECT_W-1:0]      tail_ptr_ff, tail_ptr_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [SECT_W-1:0]      head_sector_ff, head_sector_in;
   logic [NUM_SECTORS-1:0] map_ff, map_in;

   logic [SECT_W-1:0]      cur_ff, cur_in;
   logic [SECT_W-1:0]      last_ff, last_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic                   added_ff, added_in;
   logic                   touched_ff, touched_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_cmd_ff, rsp_cmd_in;
   logic [SECT_W-1:0]      rsp_sector_ff, rsp_sector_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic                   out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_next = (head_ptr_ff == SECT_W'(NUM_SECTORS - 1)) ?
                      '0 : head_ptr_ff + SECT_W'(1);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      deadline_in    = deadline_ff;
      head_ptr_in    = head_ptr_ff;
      tail_ptr_in    = tail_ptr_ff;
      count_in       = count_ff;
      head_sector_in = head_sector_ff;
      map_in         = map_ff;
      cur_in         = cur_ff;
      last_in        = last_ff;
      now_in         = now_ff;
      added_in       = added_ff;
      touched_in     = touched_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_cmd_in     = rsp_cmd_ff;
      rsp_sector_in  = rsp_sector_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_count_in   = rsp_count_ff;
      mem_we         = 1'b0;
      job_ready      = 1'b0;
      phase_eff      = (phase_ff == PH_ERASING) ? PH_DELAYING : phase_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && !job.is_tick) begin
               job_ready  = 1'b1;
               state_in   = ST_WALK;
               cur_in     = job.first_sector;
               last_in    = job.last_sector;
               now_in     = job.now_time;
               added_in   = 1'b0;
               touched_in = 1'b0;
            end else if (job_valid && out_free) begin
               job_ready = 1'b1;
               if (phase_eff == PH_DELAYING) begin
                  if (count_ff == '0) begin
                     phase_in = PH_WAITING;
                  end else if (job.now_time < deadline_ff) begin
                     phase_in = PH_DELAYING;
                  end else begin
                     // program the head sector and pop it
                     map_in[head_sector_ff] = 1'b0;
                     head_ptr_in   = head_next;
                     count_in      = count_ff - COUNT_W'(1);
                     phase_in      = PH_WAITING;
                     state_in      = ST_REFILL;
                     rsp_valid_in  = 1'b1;
                     rsp_cmd_in    = CMD_PROGRAM;
                     rsp_sector_in = head_sector_ff;
                     rsp_addr_in   = flash_base +
                                     ADDR_W'({head_sector_ff, {SECTOR_SHIFT{1'b0}}});
                     rsp_count_in  = count_ff - COUNT_W'(1);
                  end
               end else begin
                  phase_in = PH_WAITING;
                  if (count_ff != '0) begin
                     deadline_in   = job.now_time + TIME_W'(commit_delay);
                     phase_in      = PH_ERASING;
                     rsp_valid_in  = 1'b1;
                     rsp_cmd_in    = CMD_ERASE;
                     rsp_sector_in = head_sector_ff;
                     rsp_addr_in   = flash_base +
                                     ADDR_W'({head_sector_ff, {SECTOR_SHIFT{1'b0}}});
                     rsp_count_in  = count_ff;
                  end
               end
            end
         end
         ST_WALK: begin
            if (!map_ff[cur_ff]) begin
               mem_we         = 1'b1;
               map_in[cur_ff] = 1'b1;
               count_in       = count_ff + COUNT_W'(1);
               tail_ptr_in    = (tail_ptr_ff == SECT_W'(NUM_SECTORS - 1)) ?
                                '0 : tail_ptr_ff + SECT_W'(1);
               if (count_ff == '0) begin
                  head_sector_in = cur_ff;
               end
               added_in = 1'b1;
            end else if ((count_ff != '0) && (head_sector_ff == cur_ff)) begin
               touched_in = 1'b1;
            end
            if (cur_ff == last_ff) begin
               state_in = ST_IDLE;
               if (added_in) begin
                  deadline_in = '0;
               end else if (touched_in) begin
                  deadline_in = now_ff + TIME_W'(commit_delay);
               end
            end else begin
               cur_in = cur_ff + SECT_W'(1);
            end
         end
         ST_REFILL: begin
            // new head was read out of the ring on the pop edge
            head_sector_in = rd_data_ff;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_WAITING;
         deadline_ff  <= '0;
         head_ptr_ff  <= '0;
         tail_ptr_ff  <= '0;
         count_ff     <= '0;
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         deadline_ff  <= deadline_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_sector_ff <= head_sector_in;
      cur_ff         <= cur_in;
      last_ff        <= last_in;
      now_ff         <= now_in;
      added_ff       <= added_in;
      touched_ff     <= touched_in;
      rsp_cmd_ff     <= rsp_cmd_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fifo_mem[tail_ptr_ff] <= cur_ff;
      end
      rd_data_ff <= fifo_mem[head_next];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_flash_cmd     = rsp_cmd_ff;
   assign rsp_sector_index  = rsp_sector_ff;
   assign rsp_flash_address = rsp_addr_ff;
   assign rsp_pending_count = rsp_count_ff;

endmodule

@@ src/flash_sector_writeback_scheduler.sv @@
// A process tick's command passes the front register, the job queue and the
// back end's response register in order; a write notice is walked over the N
// sectors it spans (1 to 64). A program adds one ring read for the new head
// sector, a command waiting on rsp_stall holds off ticks, and a write notice
// holds the back end for its whole walk. Reset is synchronous: queue, phase,
// deadline and config registers return to defaults; ring contents stay as is.
// ----------------------------------------------------------------------------
// flash_sector_writeback_scheduler
// Top level: configuration registers, request front end, job queue and the
// flash command back end.
// ----------------------------------------------------------------------------
module flash_sector_writeback_scheduler
   import fsws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [OFFSET_W-1:0]   req_write_offset,
   input  logic [SIZE_W-1:0]     req_write_size,
   input  logic [TIME_W-1:0]     req_now_time,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_flash_cmd,
   output logic [SECT_W-1:0]     rsp_sector_index,
   output logic [ADDR_W-1:0]     rsp_flash_address,
   output logic [COUNT_W-1:0]    rsp_pending_count
);

   logic [ADDR_W-1:0]  flash_base_ff, flash_base_in;
   logic [DELAY_W-1:0] commit_delay_ff, commit_delay_in;

   logic               front_valid;
   logic               front_ready;
   job_type            front_job;
   logic               back_valid;
   logic               back_ready;
   job_type            back_job;

   always_comb begin
      flash_base_in   = flash_base_ff;
      commit_delay_in = commit_delay_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FLASH_BASE:   flash_base_in   = csr_write_data[ADDR_W-1:0];
            CSR_COMMIT_DELAY: commit_delay_in = csr_write_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_base_ff   <= '0;
         commit_delay_ff <= COMMIT_DELAY_RESET;
      end else begin
         flash_base_ff   <= flash_base_in;
         commit_delay_ff <= commit_delay_in;
      end
   end

   fsws_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_write_offset (req_write_offset),
      .req_write_size   (req_write_size),
      .req_now_time     (req_now_time),
      .job_valid        (front_valid),
      .job_ready        (front_ready),
      .job              (front_job)
   );

   fsws_job_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_job    (back_job)
   );

   fsws_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (back_valid),
      .job_ready         (back_ready),
      .job               (back_job),
      .flash_base        (flash_base_ff),
      .commit_delay      (commit_delay_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_flash_cmd     (rsp_flash_cmd),
      .rsp_sector_index  (rsp_sector_index),
      .rsp_flash_address (rsp_flash_address),
      .rsp_pending_count (rsp_pending_count)
   );

endmodule
